/* src/qcl_pkg.sv */
// Shared types and constants for the quorum consensus position tracker.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package qcl_pkg;

    localparam int MAX_NODES = 8;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int PAGE_W    = 48;
    localparam int OFF_W     = 15;
    // ordered key: {has_position, page, offset}
    localparam int KEY_W     = 1 + PAGE_W + OFF_W;
    localparam int NCFG_W    = 4;
    localparam logic [NCFG_W-1:0] NODE_COUNT_RST = NCFG_W'(8);

    typedef enum logic [1:0] {
        ACT_REPORT     = 2'd0,
        ACT_CONNECT    = 2'd1,
        ACT_DISCONNECT = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_SEARCH,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic update;
        logic search;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic search_done;
    } t_status;

endpackage

/* src/qcl_ifs.sv */
// Channel interfaces: item input, result output and configuration write.
// Depends on qcl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface qcl_in_if
    import qcl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [NODE_W-1:0] node;
    logic [PAGE_W-1:0] report_page;
    logic [OFF_W-1:0]  report_offset;

    modport source (output valid, action, node, report_page, report_offset, input ready);
    modport sink   (input valid, action, node, report_page, report_offset, output ready);
endinterface

interface qcl_out_if
    import qcl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              consensus_valid;
    logic [PAGE_W-1:0] consensus_page;
    logic [OFF_W-1:0]  consensus_offset;
    logic              quorum_met;
    logic [CNT_W-1:0]  connected_count;
    logic              stale_report;

    modport source (output valid, consensus_valid, consensus_page, consensus_offset,
                    quorum_met, connected_count, stale_report, input ready);
    modport sink   (input valid, consensus_valid, consensus_page, consensus_offset,
                    quorum_met, connected_count, stale_report, output ready);
endinterface

interface qcl_cfg_if
    import qcl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [NCFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* src/qcl_ctrl.sv */
// Controller FSM: sequences capture, state update, rank search and result load.
// Depends on qcl_pkg (t_state, t_cmd, t_status).
`timescale 1ns / 1ps
`default_nettype none

module qcl_ctrl
    import qcl_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  wire     i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_full, n_out_full;
    logic   slot_free;

    assign slot_free = !r_out_full || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_UPDATE;
            S_UPDATE: n_state = S_SEARCH;
            S_SEARCH: if (i_status.search_done) n_state = S_EMIT;
            S_EMIT:   if (slot_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_UPDATE: o_cmd.update = 1'b1;
            S_SEARCH: o_cmd.search = 1'b1;
            S_EMIT:   o_cmd.load_out = slot_free;
            default: ;
        endcase
    end

    always_comb begin
        n_out_full = r_out_full;
        if (o_cmd.load_out) begin
            n_out_full = 1'b1;
        end else if (i_out_ready) begin
            n_out_full = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_full <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_out_full <= n_out_full;
        end
    end

    assign o_out_valid = r_out_full;

`ifndef NO_ASSERTIONS
    a_accept_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_UPDATE))
        else $error("accepted transaction did not start an update");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && slot_free) |=> (r_out_full && r_state == S_IDLE))
        else $error("result not loaded into output register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_full || i_out_ready))
        else $error("output register overwritten before it was taken");
`endif

endmodule

`default_nettype wire

/* src/qcl_dpath.sv */
// Datapath: node position and connection registers, report compare,
// per-candidate rank count and result registers. Depends on qcl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qcl_dpath
    import qcl_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  wire                i_cfg_we,
    input  wire [NCFG_W-1:0]   i_cfg_data,
    input  wire [1:0]          i_action,
    input  wire [NODE_W-1:0]   i_node,
    input  wire [PAGE_W-1:0]   i_report_page,
    input  wire [OFF_W-1:0]    i_report_offset,
    output logic               o_consensus_valid,
    output logic [PAGE_W-1:0]  o_consensus_page,
    output logic [OFF_W-1:0]   o_consensus_offset,
    output logic               o_quorum_met,
    output logic [CNT_W-1:0]   o_connected_count,
    output logic               o_stale_report
);

    logic [NCFG_W-1:0]    r_node_count;
    logic [KEY_W-1:0]     r_key [MAX_NODES];
    logic [MAX_NODES-1:0] r_conn;

    logic [1:0]           r_action;
    logic [NODE_W-1:0]    r_node;
    logic [KEY_W-1:0]     r_rkey;
    logic                 r_stale;
    logic [NODE_W-1:0]    r_cand;

    logic                 r_res_valid;
    logic [PAGE_W-1:0]    r_res_page;
    logic [OFF_W-1:0]     r_res_off;
    logic                 r_res_met;
    logic [CNT_W-1:0]     r_res_cnt;
    logic                 r_res_stale;

    logic [CNT_W-1:0]     members;
    logic [MAX_NODES-1:0] member_mask;
    logic [MAX_NODES-1:0] active;
    logic [CNT_W-1:0]     conn_cnt;
    logic [CNT_W-1:0]     quorum;
    logic                 met;
    logic [CNT_W-1:0]     want;
    logic                 in_group;
    logic [KEY_W-1:0]     skey;
    logic [KEY_W-1:0]     ki;
    logic [MAX_NODES-1:0] below;
    logic [CNT_W-1:0]     rank;
    logic                 hit;
    logic                 cand_last;

    // group size clamps to the slot count
    assign members = (r_node_count > NCFG_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                          : CNT_W'(r_node_count);

    always_comb begin
        for (int j = 0; j < MAX_NODES; j++) begin
            member_mask[j] = (CNT_W'(j) < members);
        end
    end

    assign active   = r_conn & member_mask;
    assign conn_cnt = CNT_W'($countones(active));
    assign quorum   = (members >> 1) + CNT_W'(1);
    assign met      = (conn_cnt >= quorum);
    assign want     = conn_cnt - quorum;
    assign in_group = ({1'b0, r_node} < members);
    assign skey     = r_key[r_node];

    // rank of the current candidate; ties go to the lower node index
    always_comb begin
        ki    = r_key[r_cand];
        below = '0;
        for (int j = 0; j < MAX_NODES; j++) begin
            if (active[j] && (NODE_W'(j) != r_cand)) begin
                below[j] = (r_key[j] < ki) || ((r_key[j] == ki) && (NODE_W'(j) < r_cand));
            end
        end
        rank = CNT_W'($countones(below));
    end

    assign hit       = active[r_cand] && (rank == want);
    assign cand_last = (r_cand == NODE_W'(MAX_NODES - 1));
    assign o_status.search_done = !met || hit || cand_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
            r_conn       <= '0;
            for (int i = 0; i < MAX_NODES; i++) begin
                r_key[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
            if (i_cmd.update && in_group) begin
                case (t_action'(r_action))
                    ACT_REPORT: begin
                        if (r_rkey > skey) r_key[r_node] <= r_rkey;
                    end
                    ACT_CONNECT:    r_conn[r_node] <= 1'b1;
                    ACT_DISCONNECT: r_conn[r_node] <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_node   <= i_node;
            r_rkey   <= {1'b1, i_report_page, i_report_offset};
        end
        if (i_cmd.update) begin
            r_stale <= in_group && (t_action'(r_action) == ACT_REPORT) && (r_rkey < skey);
            r_cand  <= '0;
        end
        if (i_cmd.search) begin
            r_cand <= r_cand + NODE_W'(1);
            if (o_status.search_done) begin
                r_res_valid <= met && hit && ki[KEY_W-1];
                r_res_page  <= (met && hit && ki[KEY_W-1]) ? ki[KEY_W-2:OFF_W] : '0;
                r_res_off   <= (met && hit && ki[KEY_W-1]) ? ki[OFF_W-1:0] : '0;
                r_res_met   <= met;
                r_res_cnt   <= conn_cnt;
                r_res_stale <= r_stale;
            end
        end
        if (i_cmd.load_out) begin
            o_consensus_valid  <= r_res_valid;
            o_consensus_page   <= r_res_page;
            o_consensus_offset <= r_res_off;
            o_quorum_met       <= r_res_met;
            o_connected_count  <= r_res_cnt;
            o_stale_report     <= r_res_stale;
        end
    end

`ifndef NO_ASSERTIONS
    a_conn_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        conn_cnt <= members)
        else $error("connected count exceeds group size");

    a_report_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && in_group && t_action'(r_action) == ACT_REPORT && r_rkey > skey)
        |=> (r_key[$past(r_node)] == $past(r_rkey)))
        else $error("newer report not stored");

    a_stale_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && in_group && t_action'(r_action) == ACT_REPORT && r_rkey <= skey)
        |=> (r_key[$past(r_node)] == $past(skey)))
        else $error("stale or equal report changed stored position");
`endif

endmodule

`default_nettype wire

/* src/quorum_consensus_lsa_tracker.sv */
// Channel    | Dir | Payload                                              | Handshake
// i_item     | in  | action, node, report_page, report_offset             | valid/ready
// o_result   | out | consensus_valid/page/offset, quorum_met, count, stale| valid/ready
// i_cfg      | in  | data = node_count                                    | valid/ready
// An item passes from one accept to the next through the accepting idle state, the
// update state, a rank search (one step per candidate node, stopping at the pick, at
// the last node or at once when quorum is not met), then the load of the output register.
// One item is in flight at a time; the next is taken once the result has moved to
// the output register, even while that register still waits to be taken. The load
// itself waits while the output register holds a result that has not been taken.
// Synchronous active-low reset clears all positions, connections and sets node_count 8.
// Configuration writes are taken every cycle (ready held high).
`timescale 1ns / 1ps
`default_nettype none

module quorum_consensus_lsa_tracker
    import qcl_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    qcl_in_if.sink     i_item,
    qcl_out_if.source  o_result,
    qcl_cfg_if.sink    i_cfg
);

    t_cmd    cmd;
    t_status status;

    assign i_cfg.ready = 1'b1;

    qcl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    qcl_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_we           (i_cfg.valid),
        .i_cfg_data         (i_cfg.data),
        .i_action           (i_item.action),
        .i_node             (i_item.node),
        .i_report_page      (i_item.report_page),
        .i_report_offset    (i_item.report_offset),
        .o_consensus_valid  (o_result.consensus_valid),
        .o_consensus_page   (o_result.consensus_page),
        .o_consensus_offset (o_result.consensus_offset),
        .o_quorum_met       (o_result.quorum_met),
        .o_connected_count  (o_result.connected_count),
        .o_stale_report     (o_result.stale_report)
    );

endmodule

`default_nettype wire
